// ===== hw/rtl/dfpc_pkg.sv =====
// shared constants and helpers for the debounce filter with pulse count
// no dependencies
package dfpc_pkg;

  localparam int unsigned CHANNELS   = 4;
  localparam int unsigned OUT_FIELDS = 4;
  localparam int unsigned PIN_BITS   = 4;
  localparam int unsigned TICK_BITS  = 8;
  localparam int unsigned VALUE_BITS = 8;
  localparam int unsigned IDX_BITS   = 8;
  localparam int unsigned DATA_BITS  = 8;

  localparam logic [TICK_BITS-1:0] TICKS_RESET = 8'd10;
  localparam logic [PIN_BITS-1:0]  MODE_RESET  = 4'd0;
  localparam logic [PIN_BITS-1:0]  IDLE_RESET  = 4'd0;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_DEBOUNCE_TICKS = 8'd0;
  localparam logic [IDX_BITS-1:0] REG_CHANNEL_MODE   = 8'd1;
  localparam logic [IDX_BITS-1:0] REG_IDLE_LEVEL     = 8'd2;

  // channels past the pin width read as zero
  function automatic logic bit_at(logic [PIN_BITS-1:0] vec, int unsigned idx);
    logic res;
    res = 1'b0;
    if (idx < PIN_BITS) begin
      res = vec[idx[$clog2(PIN_BITS)-1:0]];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/dfpc_if.sv =====
// channel interfaces: sample, result and configuration write
// depends on dfpc_pkg
interface dfpc_sample_if;
  logic                          valid;
  logic                          ready;
  logic [dfpc_pkg::PIN_BITS-1:0] raw_pins;
  modport source (output valid, output raw_pins, input ready);
  modport sink   (input valid, input raw_pins, output ready);
endinterface

interface dfpc_result_if;
  logic                            valid;
  logic                            ready;
  logic [dfpc_pkg::VALUE_BITS-1:0] chan0_value;
  logic [dfpc_pkg::VALUE_BITS-1:0] chan1_value;
  logic [dfpc_pkg::VALUE_BITS-1:0] chan2_value;
  logic [dfpc_pkg::VALUE_BITS-1:0] chan3_value;
  modport source (output valid, output chan0_value, output chan1_value,
                  output chan2_value, output chan3_value, input ready);
  modport sink   (input valid, input chan0_value, input chan1_value,
                  input chan2_value, input chan3_value, output ready);
endinterface

interface dfpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dfpc_pkg::IDX_BITS-1:0]  index;
  logic [dfpc_pkg::DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/debounce_filter_with_pulse_count_unit.sv =====
// debounce filter with pulse count: top level
// depends on dfpc_pkg and the interfaces in dfpc_if.sv
// a sample transaction is registered straight into the result register
// throughput: one sample per cycle; the single output register drains while a new
//   sample is taken, so only a stalled, full result register holds off input
// reset: levels from idle_level (0), countdowns to debounce_ticks (10), values 0,
//   result register empty; configuration port is always ready
module debounce_filter_with_pulse_count_unit (
  input logic           clk_i,
  input logic           rst_ni,
  dfpc_sample_if.sink   sample_i,
  dfpc_result_if.source result_o,
  dfpc_cfg_if.sink      cfg_i
);

  localparam int unsigned Ch = dfpc_pkg::CHANNELS;

  // configuration registers; idle_level only acts through the reload below
  logic [dfpc_pkg::TICK_BITS-1:0] ticks_q;
  logic [dfpc_pkg::PIN_BITS-1:0]  mode_q;

  // per-channel state
  logic                            level_q [Ch];
  logic                            level_d [Ch];
  logic [dfpc_pkg::TICK_BITS-1:0]  cnt_q   [Ch];
  logic [dfpc_pkg::TICK_BITS-1:0]  cnt_d   [Ch];
  logic [dfpc_pkg::VALUE_BITS-1:0] value_q [Ch];
  logic [dfpc_pkg::VALUE_BITS-1:0] value_d [Ch];

  // result register
  logic                            out_valid_q;
  logic [dfpc_pkg::VALUE_BITS-1:0] out_q [dfpc_pkg::OUT_FIELDS];
  logic [dfpc_pkg::VALUE_BITS-1:0] out_d [dfpc_pkg::OUT_FIELDS];

  logic in_fire;
  logic cfg_fire;
  logic idle_wr;

  assign cfg_i.ready    = 1'b1;
  assign cfg_fire       = cfg_i.valid && cfg_i.ready;
  assign idle_wr        = cfg_fire && (cfg_i.index == dfpc_pkg::REG_IDLE_LEVEL);

  // take a sample whenever the result register is empty or being drained
  assign sample_i.ready = !out_valid_q || result_o.ready;
  assign in_fire        = sample_i.valid && sample_i.ready;

  // next state of every channel for the sample on the port
  always_comb begin
    logic [dfpc_pkg::TICK_BITS-1:0] dec;
    logic                           pin;
    for (int unsigned ch = 0; ch < Ch; ch++) begin
      pin          = dfpc_pkg::bit_at(sample_i.raw_pins, ch);
      dec          = cnt_q[ch] - 1'b1;
      level_d[ch]  = level_q[ch];
      value_d[ch]  = value_q[ch];
      cnt_d[ch]    = dec;
      if (pin == level_q[ch]) begin
        // stable against accepted level: rearm
        cnt_d[ch] = ticks_q;
      end else if (dec == '0) begin
        // differing level held long enough: accept it
        level_d[ch] = pin;
        cnt_d[ch]   = ticks_q;
        if (!dfpc_pkg::bit_at(mode_q, ch)) begin
          value_d[ch] = {{(dfpc_pkg::VALUE_BITS-1){1'b0}}, pin};
        end else if (!pin) begin
          // falling edge in count mode, wraps at 255
          value_d[ch] = value_q[ch] + 1'b1;
        end
      end
    end
  end

  // result fields, zero for channels not built
  for (genvar f = 0; f < dfpc_pkg::OUT_FIELDS; f++) begin : g_out
    if (f < Ch) begin : g_live
      assign out_d[f] = value_d[f];
    end else begin : g_zero
      assign out_d[f] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= dfpc_pkg::TICKS_RESET;
      mode_q  <= dfpc_pkg::MODE_RESET;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        dfpc_pkg::REG_DEBOUNCE_TICKS: ticks_q <= cfg_i.data[dfpc_pkg::TICK_BITS-1:0];
        dfpc_pkg::REG_CHANNEL_MODE:   mode_q  <= cfg_i.data[dfpc_pkg::PIN_BITS-1:0];
        dfpc_pkg::REG_IDLE_LEVEL:     ;  // levels reload in the channel state
        default: ;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned ch = 0; ch < Ch; ch++) begin
        level_q[ch] <= dfpc_pkg::bit_at(dfpc_pkg::IDLE_RESET, ch);
        cnt_q[ch]   <= dfpc_pkg::TICKS_RESET;
        value_q[ch] <= '0;
      end
    end else if (idle_wr) begin
      // idle_level write reloads levels and countdowns, values are kept
      for (int unsigned ch = 0; ch < Ch; ch++) begin
        level_q[ch] <= dfpc_pkg::bit_at(cfg_i.data[dfpc_pkg::PIN_BITS-1:0], ch);
        cnt_q[ch]   <= ticks_q;
      end
    end else if (in_fire) begin
      for (int unsigned ch = 0; ch < Ch; ch++) begin
        level_q[ch] <= level_d[ch];
        cnt_q[ch]   <= cnt_d[ch];
        value_q[ch] <= value_d[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.chan0_value = out_q[0];
  assign result_o.chan1_value = out_q[1];
  assign result_o.chan2_value = out_q[2];
  assign result_o.chan3_value = out_q[3];

  // a sample transaction always leaves a result behind
  a_fire_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("result register empty after sample transaction");

  // an empty result register never blocks input
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> sample_i.ready)
    else $error("input stalled with empty result register");

  // idle_level write rearms channel 0
  a_idle_reload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_wr |=> (cnt_q[0] == $past(ticks_q)) && (level_q[0] == $past(cfg_i.data[0])))
    else $error("idle_level write did not reload channel 0");

  // a held result keeps its channel 0 value and stays valid until taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> $stable(out_q[0]) && out_valid_q)
    else $error("stalled result changed");

endmodule
